// ===== hw/rtl/lbmt_pkg.sv =====
// constants, codes and types for the learning bridge mac table
// no dependencies; imported by learning_bridge_mac_table and its testbench
package lbmt_pkg;

   localparam int TABLE_DEPTH = 512;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int MAC_W       = 48;
   localparam int ENTRY_W     = 10;

   typedef logic [MAC_W-1:0] mac_type;
   typedef logic [CNT_W-1:0] cnt_type;

   typedef enum logic [1:0] {
      ACT_FORWARD = 2'd0,
      ACT_DISCARD = 2'd1,
      ACT_FLOOD   = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      LEARN_UPDATED = 2'd0,
      LEARN_ADDED   = 2'd1,
      LEARN_FULL    = 2'd2
   } learn_type;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_SCAN  = 3'b010,
      ST_WRITE = 3'b100
   } state_type;

endpackage

// ===== hw/rtl/learning_bridge_mac_table.sv =====
// two-port learning bridge: mac table with source learning and destination lookup
// depends on lbmt_pkg (table depth, widths, action and learn codes, state type)
// an accepted item goes through ST_SCAN, where the valid entries are compared, and ST_WRITE,
// where the source is learned and the decision made; the decision is then registered; one item
// at a time, the scan set by the single read port of the table memory, one entry a cycle
// reset (synchronous, active high) clears the entry count and control; the table
// memory itself is not cleared, only entries below the count are ever read
// results are shown for exactly one cycle, the receiver cannot stall
module learning_bridge_mac_table
   import lbmt_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [MAC_W-1:0]    req_src_mac,
   input  logic [MAC_W-1:0]    req_dst_mac,
   input  logic                req_in_port,
   output logic                rsp_valid,
   output logic [1:0]          rsp_action,
   output logic                rsp_out_port,
   output logic [1:0]          rsp_learn_status,
   output logic [ENTRY_W-1:0]  rsp_entry_count
);

   // table memory: mac in the upper bits, learned port in bit 0
   logic [MAC_W:0] table_mem [TABLE_DEPTH];

   // sequencer and scan control
   state_type state_ff, state_in;
   cnt_type   used_ff, used_in;
   cnt_type   addr_ff, addr_in;
   logic      rd_vld_ff, rd_vld_in;
   logic [ADDR_W-1:0] rd_idx_ff;
   logic [MAC_W:0]    rd_data_ff;

   // captured item
   mac_type src_ff, dst_ff;
   logic    port_ff;

   // scan results
   logic              src_hit_ff, src_hit_in;
   logic [ADDR_W-1:0] src_slot_ff;
   logic              dst_hit_ff, dst_hit_in;
   logic              dst_port_ff;

   // result registers
   logic         rsp_valid_ff, rsp_valid_in;
   action_type   action_ff, action_in;
   logic         oport_ff, oport_in;
   learn_type    learn_ff, learn_in;
   logic [ENTRY_W-1:0] count_ff;

   logic rd_en;
   logic wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic src_match, dst_match;
   logic [CNT_W+ENTRY_W-1:0] count_ext;

   // compare: one stored entry read against both source and destination
   assign src_match = rd_vld_ff && (rd_data_ff[MAC_W:1] == src_ff);
   assign dst_match = rd_vld_ff && (rd_data_ff[MAC_W:1] == dst_ff);

   always_comb begin
      state_in     = state_ff;
      used_in      = used_ff;
      addr_in      = addr_ff;
      rd_vld_in    = 1'b0;
      rd_en        = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = used_ff[ADDR_W-1:0];
      src_hit_in   = src_hit_ff;
      dst_hit_in   = dst_hit_ff;
      rsp_valid_in = 1'b0;
      action_in    = action_ff;
      oport_in     = oport_ff;
      learn_in     = learn_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in   = ST_SCAN;
               addr_in    = '0;
               src_hit_in = 1'b0;
               dst_hit_in = 1'b0;
            end
         end
         ST_SCAN: begin
            // issue one read a cycle over the valid entries, compare each in the cycle after its read
            if (addr_ff < used_ff) begin
               rd_en     = 1'b1;
               rd_vld_in = 1'b1;
               addr_in   = addr_ff + cnt_type'(1);
            end else if (!rd_vld_ff) begin
               state_in = ST_WRITE;
            end
            if (src_match) src_hit_in = 1'b1;
            if (dst_match) dst_hit_in = 1'b1;
         end
         ST_WRITE: begin
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b1;
            // learning
            if (src_hit_ff) begin
               wr_en    = 1'b1;
               wr_addr  = src_slot_ff;
               learn_in = LEARN_UPDATED;
            end else if (used_ff < cnt_type'(TABLE_DEPTH)) begin
               wr_en    = 1'b1;
               wr_addr  = used_ff[ADDR_W-1:0];
               used_in  = used_ff + cnt_type'(1);
               learn_in = LEARN_ADDED;
            end else begin
               learn_in = LEARN_FULL;
            end
            // forwarding, against the table as it stands after learning
            if ((dst_ff == src_ff) && (src_hit_ff || (used_ff < cnt_type'(TABLE_DEPTH)))) begin
               // destination is the source just learned on the arrival port
               action_in = ACT_DISCARD;
               oport_in  = port_ff;
            end else if (!dst_hit_ff) begin
               action_in = ACT_FLOOD;
               oport_in  = ~port_ff;
            end else if (dst_port_ff == port_ff) begin
               action_in = ACT_DISCARD;
               oport_in  = port_ff;
            end else begin
               action_in = ACT_FORWARD;
               oport_in  = dst_port_ff;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // entry count is reported masked to the result width
   assign count_ext = {{ENTRY_W{1'b0}}, used_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         used_ff      <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         src_hit_ff   <= 1'b0;
         dst_hit_ff   <= 1'b0;
         addr_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         src_hit_ff   <= src_hit_in;
         dst_hit_ff   <= dst_hit_in;
         addr_ff      <= addr_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && start) begin
         src_ff  <= req_src_mac;
         dst_ff  <= req_dst_mac;
         port_ff <= req_in_port;
      end
      if (src_match) src_slot_ff <= rd_idx_ff;
      if (dst_match) dst_port_ff <= rd_data_ff[0];
      if (rd_en) rd_idx_ff <= addr_ff[ADDR_W-1:0];
      if (state_ff == ST_WRITE) begin
         action_ff <= action_in;
         oport_ff  <= oport_in;
         learn_ff  <= learn_in;
         count_ff  <= count_ext[ENTRY_W-1:0];
      end
   end

   // table memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) table_mem[wr_addr] <= {src_ff, port_ff};
      if (rd_en) rd_data_ff <= table_mem[addr_ff[ADDR_W-1:0]];
   end

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_action       = action_ff;
   assign rsp_out_port     = oport_ff;
   assign rsp_learn_status = learn_ff;
   assign rsp_entry_count  = count_ff;

   // checks
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("result strobe longer than one cycle");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= cnt_type'(TABLE_DEPTH))
      else $error("entry count beyond table depth");

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted item did not start the sequencer");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && learn_ff == LEARN_FULL) |-> (used_ff == cnt_type'(TABLE_DEPTH)))
      else $error("table full reported below depth");

   a_read_in_scan: assert property (@(posedge clock) disable iff (reset)
      rd_vld_ff |-> (state_ff == ST_SCAN))
      else $error("table read outside the scan");

endmodule

// ===== tb/learning_bridge_mac_table_tb.sv =====
// testbench for learning_bridge_mac_table: frame headers in, forwarding decisions out
// depends on lbmt_pkg (types, action and learn codes) and the learning_bridge_mac_table rtl
// self-checking against an in-bench model of the learning table and lookup
`timescale 1ns / 100ps

module learning_bridge_mac_table_tb;
   import lbmt_pkg::*;

   localparam int ITEM_TARGET  = 1150;
   localparam int QUIET_TAIL   = 100;   // items at the end sent back to back
   localparam int IDLE_LIMIT   = 4000;  // cycles with no handshake before giving up
   localparam int SETTLE_WAIT  = TABLE_DEPTH + 16;
   localparam int PRINT_CAP    = 200;

   // one frame header waiting to be driven, with the idle time to leave before it
   typedef struct {
      mac_type src;
      mac_type dst;
      logic    in_port;
      int      gap;
      bit      gap_when_free;  // gap only counts down while the block is not busy
      bit      drain;          // hold the item until every decision has come back
   } frame_type;

   // forwarding decision and learning outcome for one frame
   typedef struct packed {
      action_type         action;
      logic               out_port;
      learn_type          learn;
      logic [ENTRY_W-1:0] count;
   } decision_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [MAC_W-1:0]   req_src_mac = '0;
   logic [MAC_W-1:0]   req_dst_mac = '0;
   logic               req_in_port = 1'b0;
   logic               rsp_valid;
   logic [1:0]         rsp_action;
   logic               rsp_out_port;
   logic [1:0]         rsp_learn_status;
   logic [ENTRY_W-1:0] rsp_entry_count;

   learning_bridge_mac_table u_top (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_src_mac      (req_src_mac),
      .req_dst_mac      (req_dst_mac),
      .req_in_port      (req_in_port),
      .rsp_valid        (rsp_valid),
      .rsp_action       (rsp_action),
      .rsp_out_port     (rsp_out_port),
      .rsp_learn_status (rsp_learn_status),
      .rsp_entry_count  (rsp_entry_count)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   frame_type    frame_q[$];      // headers not yet driven
   decision_type decision_q[$];   // decisions owed by the block, oldest first
   logic         learned_port[mac_type];  // the bench's own copy of the mac table

   mac_type   src_seen[$];     // source addresses the stimulus has used so far, all but the random directed one
   int        err_count = 0;
   int        n_queued = 0;
   int        quiet_from = 1 << 30;
   bit        gaps_on = 1'b1;

   // driver state
   frame_type cur;
   bit        loaded = 1'b0;
   int        gap_left = 0;
   logic      req_taken = 1'b0;
   int        idle_cycles = 0;

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      if (err_count < PRINT_CAP)
         $display("%0t mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
      err_count++;
   endtask

   // learn the source, then look the destination up in the updated table
   function automatic decision_type decide_frame(mac_type src, mac_type dst, logic in_port);
      decision_type d;
      if (learned_port.exists(src)) begin
         learned_port[src] = in_port;
         d.learn = LEARN_UPDATED;
      end else if (learned_port.num() < TABLE_DEPTH) begin
         learned_port[src] = in_port;
         d.learn = LEARN_ADDED;
      end else begin
         // table full: source refused, table left as it was
         d.learn = LEARN_FULL;
      end
      if (!learned_port.exists(dst)) begin
         d.action   = ACT_FLOOD;
         d.out_port = ~in_port;
      end else if (learned_port[dst] == in_port) begin
         d.action   = ACT_DISCARD;
         d.out_port = in_port;
      end else begin
         d.action   = ACT_FORWARD;
         d.out_port = learned_port[dst];
      end
      d.count = ENTRY_W'(learned_port.num());
      return d;
   endfunction

   function automatic mac_type rand_mac();
      logic [63:0] r;
      r = {$urandom, $urandom};
      return r[MAC_W-1:0];
   endfunction

   // fresh address with the given chance in percent, else one already used as a source
   function automatic mac_type next_src(int fresh_pct);
      mac_type m;
      if (src_seen.size() == 0 || $urandom_range(0, 99) < fresh_pct) begin
         m = rand_mac();
         src_seen.push_back(m);
      end else begin
         m = src_seen[$urandom_range(0, src_seen.size() - 1)];
      end
      return m;
   endfunction

   // mostly known destinations so that forward and discard are common
   function automatic mac_type next_dst(mac_type src);
      mac_type m;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: m = src_seen[$urandom_range(0, src_seen.size() - 1)];
         4:          m = src;
         5:          m = '1;
         6:          m = '0;
         default:    m = rand_mac();
      endcase
      return m;
   endfunction

   task automatic add_frame(input mac_type src, input mac_type dst, input logic in_port,
                            input bit drain);
      frame_type f;
      f.src           = src;
      f.dst           = dst;
      f.in_port       = in_port;
      f.drain         = drain;
      f.gap_when_free = 1'($urandom_range(0, 1));
      f.gap           = 0;
      // idle bursts come and go in stretches; none in the closing part of the run
      if ($urandom_range(0, 39) == 0)
         gaps_on = ~gaps_on;
      if (gaps_on && n_queued < quiet_from && $urandom_range(0, 2) == 0)
         f.gap = $urandom_range(1, 12);
      frame_q.push_back(f);
      n_queued++;
   endtask

   // driver: a new item goes out at the falling edge once the last one was taken
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!start || req_taken) begin
         if (!loaded && frame_q.size() != 0) begin
            cur      = frame_q.pop_front();
            loaded   = 1'b1;
            gap_left = cur.gap;
         end
         if (!loaded || (cur.drain && decision_q.size() != 0)) begin
            start <= 1'b0;
         end else if (gap_left > 0) begin
            start <= 1'b0;
            if (!cur.gap_when_free || !busy)
               gap_left--;
         end else begin
            start       <= 1'b1;
            req_src_mac <= cur.src;
            req_dst_mac <= cur.dst;
            req_in_port <= cur.in_port;
            loaded      = 1'b0;
         end
      end
   end

   // monitor: compare each strobed decision, then record what a newly taken item owes
   always @(posedge clock) begin
      decision_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         if (rsp_valid) begin
            if (decision_q.size() == 0) begin
               report_mismatch("decision with none outstanding", 64'(rsp_action), 64'(0));
            end else begin
               want = decision_q.pop_front();
               if (rsp_action !== want.action)
                  report_mismatch("action", 64'(rsp_action), 64'(want.action));
               if (rsp_out_port !== want.out_port)
                  report_mismatch("out_port", 64'(rsp_out_port), 64'(want.out_port));
               if (rsp_learn_status !== want.learn)
                  report_mismatch("learn_status", 64'(rsp_learn_status), 64'(want.learn));
               if (rsp_entry_count !== want.count)
                  report_mismatch("entry_count", 64'(rsp_entry_count), 64'(want.count));
            end
         end
         req_taken <= start && !busy;
         if (start && !busy)
            decision_q.push_back(decide_frame(req_src_mac, req_dst_mac, req_in_port));
      end
   end

   // watchdog on cycles with neither an item taken nor a decision shown
   always @(posedge clock) begin
      if (!reset) begin
         if ((start && !busy) || rsp_valid)
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   initial begin
      mac_type s;
      mac_type fresh;
      mac_type ones;
      mac_type mcast;
      mac_type alt_a;
      mac_type alt_5;
      mac_type uni_x;
      int      n_tail;

      ones  = '1;
      mcast = 48'h0100_5E00_0001;
      alt_a = 48'hAAAA_AAAA_AAAA;
      alt_5 = 48'h5555_5555_5555;
      uni_x = 48'h0012_3456_789A;

      // directed part, empty table
      add_frame('0,    '0,    1'b0, 1'b0);  // destination is the source: discard
      add_frame(ones,  '0,    1'b1, 1'b0);  // broadcast source learned, forward to 0
      add_frame('0,    ones,  1'b1, 1'b0);  // port moves, broadcast dest on same port
      add_frame(mcast, uni_x, 1'b0, 1'b0);  // unknown dest floods to port 1
      add_frame(uni_x, mcast, 1'b1, 1'b0);  // multicast looked up like any address
      add_frame(alt_a, alt_5, 1'b0, 1'b0);
      add_frame(alt_5, alt_a, 1'b1, 1'b0);
      add_frame(alt_a, alt_5, 1'b1, 1'b0);
      add_frame(alt_a, alt_a, 1'b0, 1'b0);
      add_frame(alt_5, uni_x, 1'b0, 1'b0);
      add_frame(uni_x, alt_5, 1'b0, 1'b0);
      add_frame(ones,  ones,  1'b0, 1'b0);
      add_frame(48'h0000_0000_0001, 48'h8000_0000_0000, 1'b1, 1'b0);
      add_frame(48'h8000_0000_0000, 48'h0000_0000_0001, 1'b0, 1'b0);
      add_frame(rand_mac(), ones, 1'b1, 1'b0);  // broadcast now on port 0: forward from 1
      src_seen = '{'0, ones, mcast, uni_x, alt_a, alt_5,
                   48'h0000_0000_0001, 48'h8000_0000_0000};

      // small table: mostly known addresses, so updates, forwards and discards
      for (int i = 0; i < 400; i++) begin
         s = next_src(20);
         add_frame(s, next_dst(s), 1'($urandom_range(0, 1)), i == 0);
      end

      // fill the table and go some way past full
      s = next_src(85);
      add_frame(s, next_dst(s), 1'($urandom_range(0, 1)), 1'b1);
      while (src_seen.size() < TABLE_DEPTH + 20) begin
         s = next_src(85);
         add_frame(s, next_dst(s), 1'($urandom_range(0, 1)), 1'b0);
      end

      // full table: refused source looked up as its own destination floods
      n_tail     = (ITEM_TARGET - n_queued > 150) ? ITEM_TARGET - n_queued : 150;
      quiet_from = n_queued + n_tail - QUIET_TAIL;
      fresh = rand_mac();
      src_seen.push_back(fresh);
      add_frame(fresh, fresh, 1'b0, 1'b1);
      add_frame(fresh, '0, 1'b1, 1'b0);
      add_frame(src_seen[5], src_seen[5], 1'b1, 1'b0);
      for (int i = 3; i < n_tail; i++) begin
         s = next_src(30);
         add_frame(s, next_dst(s), 1'($urandom_range(0, 1)), 1'b0);
      end

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (frame_q.size() != 0 || loaded || start || decision_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE_WAIT) @(posedge clock);

      if (err_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
